[src/si_pkg.sv]
package si_pkg;

  localparam int CW   = 16;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int SUMW = PW + 1;
  localparam int NW   = 2 * CW + 2;
  localparam int SW   = NW + CW;
  localparam int FRONT_STAGES = 5;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_HIT  = 2'd1,
    ST_COIN = 2'd2
  } status_e;

  typedef struct packed {
    status_e              status;
    logic signed [CW-1:0] mid_x;
    logic signed [CW-1:0] mid_y;
    logic signed [CW-1:0] base_x;
    logic signed [CW-1:0] base_y;
    logic                 neg_x;
    logic                 neg_y;
    logic [NW-1:0]        den;
    logic [NW-1:0]        rx;
    logic [NW-1:0]        ry;
    logic [CW-1:0]        lx;
    logic [CW-1:0]        ly;
  } div_t;

endpackage

[src/si_front.sv]
module si_front
  import si_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [CW-1:0] crd_i [8],
  output logic                 valid_o,
  input  logic                 ready_i,
  output div_t                 data_o
);

  logic [FRONT_STAGES-1:0] v_q;
  logic [FRONT_STAGES-1:0] en;

  always_comb begin
    en[FRONT_STAGES-1] = !v_q[FRONT_STAGES-1] || ready_i;
    for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[FRONT_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Differences.
  logic signed [CW-1:0] c1_q [8];
  logic signed [DW-1:0] dxa1_q, dya1_q, dxb1_q, dyb1_q, ex1_q, ey1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      c1_q   <= crd_i;
      dxa1_q <= DW'(crd_i[2]) - DW'(crd_i[0]);
      dya1_q <= DW'(crd_i[3]) - DW'(crd_i[1]);
      dxb1_q <= DW'(crd_i[6]) - DW'(crd_i[4]);
      dyb1_q <= DW'(crd_i[7]) - DW'(crd_i[5]);
      ex1_q  <= DW'(crd_i[0]) - DW'(crd_i[4]);
      ey1_q  <= DW'(crd_i[1]) - DW'(crd_i[5]);
    end
  end

  // Cross products and squared lengths.
  logic signed [CW-1:0] c2_q [8];
  logic signed [DW-1:0] dxa2_q, dya2_q;
  logic signed [PW-1:0] md1_q, md2_q, ma1_q, ma2_q, mb1_q, mb2_q;
  logic signed [PW-1:0] sa1_q, sa2_q, sb1_q, sb2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      c2_q   <= c1_q;
      dxa2_q <= dxa1_q;
      dya2_q <= dya1_q;
      md1_q  <= PW'(dyb1_q) * PW'(dxa1_q);
      md2_q  <= PW'(dxb1_q) * PW'(dya1_q);
      ma1_q  <= PW'(dxb1_q) * PW'(ey1_q);
      ma2_q  <= PW'(dyb1_q) * PW'(ex1_q);
      mb1_q  <= PW'(dxa1_q) * PW'(ey1_q);
      mb2_q  <= PW'(dya1_q) * PW'(ex1_q);
      sa1_q  <= PW'(dxa1_q) * PW'(dxa1_q);
      sa2_q  <= PW'(dya1_q) * PW'(dya1_q);
      sb1_q  <= PW'(dxb1_q) * PW'(dxb1_q);
      sb2_q  <= PW'(dyb1_q) * PW'(dyb1_q);
    end
  end

  // Denominator, numerators and lengths.
  logic signed [CW-1:0]   c3_q [8];
  logic signed [DW-1:0]   dxa3_q, dya3_q;
  logic signed [SUMW-1:0] den3_q, na3_q, nb3_q;
  logic [NW-1:0]          la3_q, lb3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c3_q   <= c2_q;
      dxa3_q <= dxa2_q;
      dya3_q <= dya2_q;
      den3_q <= SUMW'(md1_q) - SUMW'(md2_q);
      na3_q  <= SUMW'(ma1_q) - SUMW'(ma2_q);
      nb3_q  <= SUMW'(mb1_q) - SUMW'(mb2_q);
      la3_q  <= NW'($unsigned(sa1_q)) + NW'($unsigned(sa2_q));
      lb3_q  <= NW'($unsigned(sb1_q)) + NW'($unsigned(sb2_q));
    end
  end

  // Classification and midpoint.
  logic signed [SUMW-1:0] dn, nan, nbn;
  logic                   coin, hit, pick_a;
  logic signed [CW-1:0]   mx, my;

  function automatic logic signed [CW-1:0] midp(logic signed [CW-1:0] p,
                                                logic signed [CW-1:0] q);
    logic signed [DW-1:0] s;
    logic signed [DW-1:0] h;
    s = DW'(p) + DW'(q);
    h = s >>> 1;
    if (s[DW-1] && s[0]) begin
      h = h + DW'(1);
    end
    return h[CW-1:0];
  endfunction

  always_comb begin
    dn     = den3_q[SUMW-1] ? -den3_q : den3_q;
    nan    = den3_q[SUMW-1] ? -na3_q : na3_q;
    nbn    = den3_q[SUMW-1] ? -nb3_q : nb3_q;
    coin   = (den3_q == '0) && (na3_q == '0) && (nb3_q == '0);
    hit    = (den3_q != '0) && !nan[SUMW-1] && !nbn[SUMW-1] && (nan <= dn) && (nbn <= dn);
    pick_a = la3_q < lb3_q;
    mx     = pick_a ? midp(c3_q[0], c3_q[2]) : midp(c3_q[4], c3_q[6]);
    my     = pick_a ? midp(c3_q[1], c3_q[3]) : midp(c3_q[5], c3_q[7]);
  end

  status_e              st4_q;
  logic signed [CW-1:0] mx4_q, my4_q, bx4_q, by4_q;
  logic                 negx4_q, negy4_q;
  logic [NW-1:0]        den4_q, na4_q;
  logic [CW-1:0]        ux4_q, uy4_q;
  logic signed [DW-1:0] ax_abs, ay_abs;

  always_comb begin
    ax_abs = dxa3_q[DW-1] ? -dxa3_q : dxa3_q;
    ay_abs = dya3_q[DW-1] ? -dya3_q : dya3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      priority if (coin) begin
        st4_q <= ST_COIN;
      end else if (hit) begin
        st4_q <= ST_HIT;
      end else begin
        st4_q <= ST_NONE;
      end
      mx4_q   <= mx;
      my4_q   <= my;
      bx4_q   <= c3_q[0];
      by4_q   <= c3_q[1];
      negx4_q <= dxa3_q[DW-1];
      negy4_q <= dya3_q[DW-1];
      den4_q  <= dn[NW-1:0];
      na4_q   <= nan[NW-1:0];
      ux4_q   <= ax_abs[CW-1:0];
      uy4_q   <= ay_abs[CW-1:0];
    end
  end

  // Scaled dividends.
  logic [SW-1:0] px, py;

  always_comb begin
    px = SW'(na4_q) * SW'(ux4_q);
    py = SW'(na4_q) * SW'(uy4_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      data_o.status <= st4_q;
      data_o.mid_x  <= mx4_q;
      data_o.mid_y  <= my4_q;
      data_o.base_x <= bx4_q;
      data_o.base_y <= by4_q;
      data_o.neg_x  <= negx4_q;
      data_o.neg_y  <= negy4_q;
      data_o.den    <= den4_q;
      data_o.rx     <= px[SW-1:CW];
      data_o.ry     <= py[SW-1:CW];
      data_o.lx     <= px[CW-1:0];
      data_o.ly     <= py[CW-1:0];
    end
  end

  a_coin_den_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && st4_q == ST_COIN) |-> (den4_q == '0))
    else $error("coincident result with non-zero denominator");

endmodule

[src/si_div.sv]
module si_div
  import si_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  div_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output div_t data_o
);

  div_t          st_q [CW];
  logic [CW-1:0] v_q;
  logic [CW-1:0] en;

  function automatic div_t step(div_t a);
    div_t          r;
    logic [NW:0]   tx, ty;
    logic          gx, gy;
    r  = a;
    tx = {a.rx, a.lx[CW-1]};
    ty = {a.ry, a.ly[CW-1]};
    gx = tx >= {1'b0, a.den};
    gy = ty >= {1'b0, a.den};
    r.rx = gx ? NW'(tx - {1'b0, a.den}) : tx[NW-1:0];
    r.ry = gy ? NW'(ty - {1'b0, a.den}) : ty[NW-1:0];
    r.lx = {a.lx[CW-2:0], gx};
    r.ly = {a.ly[CW-2:0], gy};
    return r;
  endfunction

  always_comb begin
    en[CW-1] = !v_q[CW-1] || ready_i;
    for (int k = CW - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[CW-1];
  assign data_o  = st_q[CW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < CW; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      st_q[0] <= step(data_i);
    end
    for (int k = 1; k < CW; k++) begin
      if (en[k]) begin
        st_q[k] <= step(st_q[k-1]);
      end
    end
  end

endmodule

[src/segment_intersection.sv]
// Channel  | Direction | Fields, lowest bit first
// s_axis   | in        | tdata: ax0 ay0 ax1 ay1 bx0 by0 bx1 by1, 16 bits each
// m_axis   | out       | tdata: hit_x[15:0] hit_y[31:16]; tuser: status[1:0]
//
// One transaction is accepted per cycle while no stall backs up to the input;
// the path runs through five arithmetic stages, one restoring-divider stage per
// quotient bit, and the output register.
// Reset clears only the valid bits of the pipeline.
// A stalled stage holds its contents; bubbles close up, so input is taken
// whenever any stage ahead is free.
module segment_intersection
  import si_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // ax0, ay0, ax1, ay1, bx0, by0, bx1, by1
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // hit_x, hit_y
  output logic [1:0]   m_axis_tuser   // status
);

  logic signed [CW-1:0] crd [8];
  logic                 f_valid, f_ready, d_valid, d_ready, out_en;
  div_t                 f_data, d_data;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      crd[k] = s_axis_tdata[k*CW +: CW];
    end
  end

  si_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .crd_i   (crd),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .data_o  (f_data)
  );

  si_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .data_i  (f_data),
    .valid_o (d_valid),
    .ready_i (d_ready),
    .data_o  (d_data)
  );

  function automatic logic signed [CW-1:0] place(logic signed [CW-1:0] b,
                                                 logic neg, logic [CW-1:0] q);
    logic signed [CW+1:0] s;
    s = neg ? ((CW+2)'(b) - $signed({2'b00, q})) : ((CW+2)'(b) + $signed({2'b00, q}));
    if (s > (CW+2)'($signed({1'b0, {(CW-1){1'b1}}}))) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (s < -(CW+2)'($signed({1'b0, 1'b1, {(CW-1){1'b0}}}))) begin
      return {1'b1, {(CW-1){1'b0}}};
    end
    return s[CW-1:0];
  endfunction

  status_e              st_d, st_q;
  logic signed [CW-1:0] hx_d, hx_q, hy_d, hy_q;
  logic                 ov_q;

  always_comb begin
    st_d = d_data.status;
    unique case (d_data.status)
      ST_HIT: begin
        hx_d = place(d_data.base_x, d_data.neg_x, d_data.lx);
        hy_d = place(d_data.base_y, d_data.neg_y, d_data.ly);
      end
      ST_COIN: begin
        hx_d = d_data.mid_x;
        hy_d = d_data.mid_y;
      end
      default: begin
        hx_d = '0;
        hy_d = '0;
      end
    endcase
  end

  assign out_en  = !ov_q || m_axis_tready;
  assign d_ready = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_en) begin
      ov_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      st_q <= st_d;
      hx_q <= hx_d;
      hy_q <= hy_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {hy_q, hx_q};
  assign m_axis_tuser  = st_q;

  a_no_stall_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input held off while the output is free");

  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && st_q == ST_NONE) |-> (hx_q == '0 && hy_q == '0))
    else $error("non-zero point without an intersection");

endmodule

[tb/sv/segment_intersection_tb.sv]
`timescale 1ns / 1ps

module segment_intersection_tb;
  import si_pkg::*;

  typedef struct {
    logic signed [15:0] c[8];
  } seg_pair_t;

  typedef struct {
    status_e            status;
    logic signed [15:0] hx;
    logic signed [15:0] hy;
  } isect_t;

  // Exact intersection of two segments, with widths large enough for every product.
  function automatic isect_t predict_isect(seg_pair_t p);
    isect_t r;
    logic signed [20:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [20:0] dxa, dya, dxb, dyb, ex, ey;
    logic signed [63:0] den, na, nb, la, lb, q, v;
    x1 = p.c[0]; y1 = p.c[1]; x2 = p.c[2]; y2 = p.c[3];
    x3 = p.c[4]; y3 = p.c[5]; x4 = p.c[6]; y4 = p.c[7];
    dxa = x2 - x1; dya = y2 - y1; dxb = x4 - x3; dyb = y4 - y3;
    ex = x1 - x3; ey = y1 - y3;
    den = 64'(dyb) * 64'(dxa) - 64'(dxb) * 64'(dya);
    na = 64'(dxb) * 64'(ey) - 64'(dyb) * 64'(ex);
    nb = 64'(dxa) * 64'(ey) - 64'(dya) * 64'(ex);
    r.status = ST_NONE;
    r.hx = '0;
    r.hy = '0;
    if (den == 0 && na == 0 && nb == 0) begin
      la = 64'(dxa) * 64'(dxa) + 64'(dya) * 64'(dya);
      lb = 64'(dxb) * 64'(dxb) + 64'(dyb) * 64'(dyb);
      r.status = ST_COIN;
      if (la < lb) begin
        r.hx = 16'((x1 + x2) / 2);
        r.hy = 16'((y1 + y2) / 2);
      end else begin
        r.hx = 16'((x3 + x4) / 2);
        r.hy = 16'((y3 + y4) / 2);
      end
    end else if (den != 0) begin
      if (den < 0) begin
        den = -den; na = -na; nb = -nb;
      end
      if (na >= 0 && nb >= 0 && na <= den && nb <= den) begin
        r.status = ST_HIT;
        q = (na * (dxa < 0 ? -64'(dxa) : 64'(dxa))) / den;
        v = dxa < 0 ? 64'(x1) - q : 64'(x1) + q;
        r.hx = v > 32767 ? 16'sh7fff : (v < -32768 ? 16'sh8000 : 16'(v));
        q = (na * (dya < 0 ? -64'(dya) : 64'(dya))) / den;
        v = dya < 0 ? 64'(y1) - q : 64'(y1) + q;
        r.hy = v > 32767 ? 16'sh7fff : (v < -32768 ? 16'sh8000 : 16'(v));
      end
    end
    return r;
  endfunction

  class isect_scoreboard;
    isect_t pending[$];
    int     mismatches;

    function void note_pair(seg_pair_t p);
      pending.push_back(predict_isect(p));
    endfunction

    function void check_result(logic [1:0] u, logic [31:0] d);
      isect_t e;
      if (pending.size() == 0) begin
        report_bad("unexpected transaction", u, d, e);
        return;
      end
      e = pending.pop_front();
      if (u !== e.status || d[15:0] !== e.hx || d[31:16] !== e.hy)
        report_bad("mismatch", u, d, e);
    endfunction

    function void report_bad(string what, logic [1:0] u, logic [31:0] d, isect_t e);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected status %0d x %0d y %0d, got status %0d x %0d y %0d (raw %h)",
                 what, e.status, e.hx, e.hy, u, $signed(d[15:0]), $signed(d[31:16]), d);
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  isect_scoreboard sb;
  int  cycles;
  bit  feeding_done;
  bit  sink_stalls;

  segment_intersection u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    sink_stalls = 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  initial begin : sink
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = sink_stalls ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_pair(seg_pair_t p, bit with_gaps);
    int gap;
    gap = with_gaps ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    for (int i = 0; i < 8; i++) s_axis_tdata[16*i +: 16] = p.c[i];
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pair(p);
    @(negedge clk_i);
  endtask

  function automatic seg_pair_t make_pair(int a0, int a1, int a2, int a3,
                                          int b0, int b1, int b2, int b3);
    seg_pair_t p;
    p.c[0] = 16'(a0); p.c[1] = 16'(a1); p.c[2] = 16'(a2); p.c[3] = 16'(a3);
    p.c[4] = 16'(b0); p.c[5] = 16'(b1); p.c[6] = 16'(b2); p.c[7] = 16'(b3);
    return p;
  endfunction

  // Half of the pairs use small coordinates so that many cross, with full-range, collinear and parallel cases mixed in.
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int kind;
    int span;
    int t1, t2;
    kind = $urandom_range(0, 9);
    span = (kind < 5) ? 64 : 32767;
    for (int i = 0; i < 8; i++)
      p.c[i] = (kind == 9) ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
    if (kind == 7) begin
      t1 = $urandom_range(0, 6) - 3;
      t2 = $urandom_range(0, 6) - 3;
      p.c[4] = 16'(p.c[0] + t1 * (p.c[2] - p.c[0]) / 2);
      p.c[5] = 16'(p.c[1] + t1 * (p.c[3] - p.c[1]) / 2);
      p.c[6] = 16'(p.c[0] + t2 * (p.c[2] - p.c[0]) / 2);
      p.c[7] = 16'(p.c[1] + t2 * (p.c[3] - p.c[1]) / 2);
      p.c[2] = 16'(p.c[0] + 2 * ((p.c[2] - p.c[0]) / 2));
      p.c[3] = 16'(p.c[1] + 2 * ((p.c[3] - p.c[1]) / 2));
    end else if (kind == 8) begin
      p.c[6] = p.c[4] + (p.c[2] - p.c[0]);
      p.c[7] = p.c[5] + (p.c[3] - p.c[1]);
    end
    return p;
  endfunction

  initial begin : source
    seg_pair_t directed[$];
    directed.push_back(make_pair(0, 0, 32, 32, 0, 32, 32, 0));
    directed.push_back(make_pair(0, 0, 16, 16, 16, 16, 32, 0));
    directed.push_back(make_pair(0, 0, 16, 0, 0, 16, 16, 16));
    directed.push_back(make_pair(0, 0, 32, 0, 8, 0, 16, 0));
    directed.push_back(make_pair(0, 0, 16, 0, -5, 0, 11, 0));
    directed.push_back(make_pair(-3, -3, -3, -3, -3, -3, -3, -3));
    directed.push_back(make_pair(0, 0, 16, 16, 0, 40, 40, 32));
    directed.push_back(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    directed.push_back(make_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
    directed.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    directed.push_back(make_pair(-32768, -32768, 32767, -32768, 0, 0, 0, 0));
    directed.push_back(make_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
    directed.push_back(make_pair(0, 0, 10, 3, 0, 3, 10, 0));
    directed.push_back(make_pair(0, 0, -10, -3, 0, -3, -10, 0));
    directed.push_back(make_pair(0, 0, 16, 0, 17, -5, 17, 5));
    directed.push_back(make_pair(0, 0, 16, 0, 8, 1, 8, 5));
    directed.push_back(make_pair(-1, -1, -1, -1, 0, 0, 0, 0));
    @(posedge rst_ni);
    @(negedge clk_i);
    foreach (directed[i]) send_pair(directed[i], 1'b0);
    for (int n = 0; n < 400; n++) begin
      if (n == 150) begin
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk_i);
      end
      sink_stalls = !(n >= 250 && n < 300);
      send_pair(random_pair(), !(n >= 200 && n < 260));
    end
    s_axis_tvalid = 1'b0;
    sink_stalls = 1'b1;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
